[design/spherical_harmonic_point_eval_unit_macros.svh]
// Assertion helpers for the spherical harmonic point evaluator.
`ifndef SPHERICAL_HARMONIC_POINT_EVAL_UNIT_MACROS_SVH
`define SPHERICAL_HARMONIC_POINT_EVAL_UNIT_MACROS_SVH

// Clocked assertion with explicit clock and reset.
`define SHPE_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define SHPE_ASSERT(lbl, prop, msg) `SHPE_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

[design/shpe_pkg.sv]
package shpe_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QB        = 30;

   // pipeline depths
   localparam int SQRT_STAGES  = 32;
   localparam int DIV_STAGES   = QB + 1;
   localparam int FRONT_STAGES = 5;
   localparam int BACK_STAGES  = 6;
   localparam int PIPE_LAT     = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + BACK_STAGES;

   localparam int ROOT_W = 33;

   // csr register indexes
   localparam logic [1:0] CSR_DEGREE    = 2'd0;
   localparam logic [1:0] CSR_ORDER     = 2'd1;
   localparam logic [1:0] CSR_AMPLITUDE = 2'd2;
   localparam logic [1:0] CSR_FLOOR     = 2'd3;

   localparam logic [31:0] AMP_RESET = 32'(64'd1 << FRAC_BITS);

   // Q2.30 working values, with headroom
   typedef logic signed [33:0] qval_type;

   localparam qval_type QONE  = qval_type'(64'd1 << QB);
   localparam qval_type K_Y00 = 34'sd302896976;
   localparam qval_type K_Y10 = 34'sd524632952;
   localparam qval_type K_Y11 = 34'sd370971518;
   localparam qval_type K_Y21 = 34'sd829517532;
   localparam qval_type K_Y22 = 34'sd414758766;
   localparam qval_type K_Y20 = 34'sd338649115;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] field_real;
      logic signed [31:0] field_imag;
      logic               bad_mode;
   } rsp_type;

   // sign-magnitude product, truncated toward zero, QB fraction bits dropped
   function automatic qval_type mulq(input qval_type a, input qval_type b);
      logic [33:0] ma;
      logic [33:0] mb;
      logic [67:0] prod;
      logic [33:0] mt;
      ma   = a[33] ? $unsigned(-a) : $unsigned(a);
      mb   = b[33] ? $unsigned(-b) : $unsigned(b);
      prod = ma * mb;
      mt   = prod[QB+33:QB];
      return (a[33] ^ b[33]) ? -$signed(mt) : $signed(mt);
   endfunction

endpackage

[design/shpe_isqrt.sv]
module shpe_isqrt import shpe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [63:0]       in_value,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root
);

   logic [63:0]            rem_ff [SQRT_STAGES];
   logic [63:0]            res_ff [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] vld_ff;

   // one result bit per stage, MSB first
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] rem_cur;
      logic [63:0] res_cur;
      logic [63:0] trial;
      logic [63:0] rem_in;
      logic [63:0] res_in;

      if (k == 0) begin : g_first
         assign rem_cur = in_value;
         assign res_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign res_cur = res_ff[k-1];
      end

      assign trial = res_cur + BIT;

      always_comb begin
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            res_in = (res_cur >> 1) + BIT;
         end else begin
            rem_in = rem_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         res_ff[k] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[SQRT_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES-1];
   assign out_root  = res_ff[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

[design/shpe_div.sv]
module shpe_div import shpe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        in_num,
   input  logic               in_neg,
   input  logic [ROOT_W-1:0]  in_den,
   output logic               out_valid,
   output logic signed [31:0] out_q
);

   logic [63:0]           rem_ff  [DIV_STAGES];
   logic [DIV_STAGES-1:0] q_ff    [DIV_STAGES];
   logic [ROOT_W-1:0]     den_ff  [DIV_STAGES];
   logic                  zero_ff [DIV_STAGES];
   logic                  neg_ff  [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;
   logic [31:0]           mag;

   // restoring division, one quotient bit per stage, MSB first
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
      localparam int SH = DIV_STAGES - 1 - s;
      logic [63:0]           rem_cur;
      logic [63:0]           dsh;
      logic [63:0]           rem_in;
      logic [DIV_STAGES-1:0] q_cur;
      logic [DIV_STAGES-1:0] q_in;
      logic [ROOT_W-1:0]     den_cur;
      logic                  zero_cur;
      logic                  neg_cur;

      if (s == 0) begin : g_first
         assign rem_cur  = 64'(in_num) << QB;
         assign q_cur    = '0;
         assign den_cur  = in_den;
         assign zero_cur = (in_den == '0);
         assign neg_cur  = in_neg;
      end else begin : g_next
         assign rem_cur  = rem_ff[s-1];
         assign q_cur    = q_ff[s-1];
         assign den_cur  = den_ff[s-1];
         assign zero_cur = zero_ff[s-1];
         assign neg_cur  = neg_ff[s-1];
      end

      assign dsh = 64'(den_cur) << SH;

      always_comb begin
         if (rem_cur >= dsh) begin
            rem_in = rem_cur - dsh;
            q_in   = {q_cur[DIV_STAGES-2:0], 1'b1};
         end else begin
            rem_in = rem_cur;
            q_in   = {q_cur[DIV_STAGES-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         q_ff[s]    <= q_in;
         den_ff[s]  <= den_cur;
         zero_ff[s] <= zero_cur;
         neg_ff[s]  <= neg_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   // zero divisor gives zero
   assign mag       = zero_ff[DIV_STAGES-1] ? '0 : 32'(q_ff[DIV_STAGES-1]);
   assign out_q     = neg_ff[DIV_STAGES-1] ? -$signed(mag) : $signed(mag);
   assign out_valid = vld_ff[DIV_STAGES-1];

endmodule

[design/spherical_harmonic_point_eval_unit.sv]
// Spherical harmonic point evaluator, degree 0..2.
//
// Input: one grid point (pos_x, pos_y, pos_z, signed Q16.16) per item on
// req_data, taken at a clock edge with start high and busy low. busy is
// always low: a new point can be taken in every cycle.
// Output: rsp_valid strobes for one cycle with field_real, field_imag and
// bad_mode on rsp_data. There is no backpressure; the sink must take it.
// One item per cycle is sustained through 5 front stages (abs, squares,
// sums, floor), a 32-stage square root, a 31-stage divider and 6 stages of
// products, mode select and saturation.
// The user writes configuration (degree, order, amplitude, radius_sq_floor)
// through csr_we / csr_index / csr_wdata only while no items are in flight;
// not enforced by the block. Synchronous reset clears all valid bits, drops
// in-flight items and returns degree 0, order 0, amplitude 1.0, floor 1.
`include "spherical_harmonic_point_eval_unit_macros.svh"

module spherical_harmonic_point_eval_unit import shpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [61:0] csr_wdata
);

   typedef struct packed {
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      logic [31:0] mag_z;
      logic        neg_x;
      logic        neg_y;
      logic        neg_z;
   } side_type;

   localparam qval_type SAT_MAX = 34'sd2147483647;
   localparam qval_type SAT_MIN = -34'sd2147483648;

   // ---------------- configuration registers ----------------
   logic [1:0]         degree_ff;
   logic signed [2:0]  order_ff;
   logic signed [31:0] amplitude_ff;
   logic [61:0]        floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff    <= '0;
         order_ff     <= '0;
         amplitude_ff <= AMP_RESET;
         floor_ff     <= 62'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEGREE:    degree_ff    <= csr_wdata[1:0];
            CSR_ORDER:     order_ff     <= csr_wdata[2:0];
            CSR_AMPLITUDE: amplitude_ff <= csr_wdata[31:0];
            CSR_FLOOR:     floor_ff     <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // mode decode; legal pairs are |order| <= degree <= 2
   logic signed [3:0] ord4;
   logic signed [3:0] deg4;
   logic              bad;

   assign ord4 = {order_ff[2], order_ff};
   assign deg4 = {2'b00, degree_ff};
   assign bad  = (degree_ff == 2'd3) || (ord4 > deg4) || (ord4 < -deg4);

   assign busy = 1'b0;

   // ---------------- front end ----------------
   logic [FRONT_STAGES-1:0] fvld_ff;
   side_type                s0_side_ff, s1_side_ff, s2_side_ff, s3_side_ff, s4_side_ff;
   logic [63:0]             s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;
   logic [63:0]             s2_rho2_ff, s2_sqz_ff;
   logic [63:0]             s3_r2_ff, s3_rho2_ff;
   logic [63:0]             s4_r2_ff, s4_rho2_ff;
   logic [63:0]             floor64;

   assign floor64 = 64'(floor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fvld_ff <= '0;
      end else begin
         fvld_ff <= {fvld_ff[FRONT_STAGES-2:0], start & ~busy};
      end
   end

   always_ff @(posedge clock) begin
      // magnitudes and signs
      s0_side_ff.mag_x <= req_data.pos_x[31] ? 32'(-req_data.pos_x) : 32'(req_data.pos_x);
      s0_side_ff.mag_y <= req_data.pos_y[31] ? 32'(-req_data.pos_y) : 32'(req_data.pos_y);
      s0_side_ff.mag_z <= req_data.pos_z[31] ? 32'(-req_data.pos_z) : 32'(req_data.pos_z);
      s0_side_ff.neg_x <= req_data.pos_x[31];
      s0_side_ff.neg_y <= req_data.pos_y[31];
      s0_side_ff.neg_z <= req_data.pos_z[31];
      // squares
      s1_sqx_ff  <= 64'(s0_side_ff.mag_x) * 64'(s0_side_ff.mag_x);
      s1_sqy_ff  <= 64'(s0_side_ff.mag_y) * 64'(s0_side_ff.mag_y);
      s1_sqz_ff  <= 64'(s0_side_ff.mag_z) * 64'(s0_side_ff.mag_z);
      s1_side_ff <= s0_side_ff;
      // rho^2
      s2_rho2_ff <= s1_sqx_ff + s1_sqy_ff;
      s2_sqz_ff  <= s1_sqz_ff;
      s2_side_ff <= s1_side_ff;
      // r^2, floor on rho^2
      s3_r2_ff   <= s2_rho2_ff + s2_sqz_ff;
      s3_rho2_ff <= (s2_rho2_ff < floor64) ? floor64 : s2_rho2_ff;
      s3_side_ff <= s2_side_ff;
      // floor on r^2
      s4_r2_ff   <= (s3_r2_ff < floor64) ? floor64 : s3_r2_ff;
      s4_rho2_ff <= s3_rho2_ff;
      s4_side_ff <= s3_side_ff;
   end

   // ---------------- square roots ----------------
   logic              sq_vld_r, sq_vld_rho, sq_vld;
   logic [ROOT_W-1:0] r_root, rho_root;
   side_type          dly_ff [SQRT_STAGES];

   shpe_isqrt u_sqrt_r (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fvld_ff[FRONT_STAGES-1]),
      .in_value  (s4_r2_ff),
      .out_valid (sq_vld_r),
      .out_root  (r_root)
   );

   shpe_isqrt u_sqrt_rho (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fvld_ff[FRONT_STAGES-1]),
      .in_value  (s4_rho2_ff),
      .out_valid (sq_vld_rho),
      .out_root  (rho_root)
   );

   assign sq_vld = sq_vld_r & sq_vld_rho;

   // coordinates ride alongside the root pipeline
   always_ff @(posedge clock) begin
      dly_ff[0] <= s4_side_ff;
      for (int j = 1; j < SQRT_STAGES; j++) begin
         dly_ff[j] <= dly_ff[j-1];
      end
   end

   // ---------------- angle ratios ----------------
   side_type           side_q;
   logic               vld_ct, vld_st, vld_cp, vld_sp, div_vld;
   logic signed [31:0] ct, st, cp, sp;

   assign side_q = dly_ff[SQRT_STAGES-1];

   shpe_div u_div_ct (
      .clock (clock), .reset (reset), .in_valid (sq_vld),
      .in_num (side_q.mag_z), .in_neg (side_q.neg_z), .in_den (r_root),
      .out_valid (vld_ct), .out_q (ct)
   );

   shpe_div u_div_st (
      .clock (clock), .reset (reset), .in_valid (sq_vld),
      .in_num (rho_root[31:0]), .in_neg (1'b0), .in_den (r_root),
      .out_valid (vld_st), .out_q (st)
   );

   shpe_div u_div_cp (
      .clock (clock), .reset (reset), .in_valid (sq_vld),
      .in_num (side_q.mag_x), .in_neg (side_q.neg_x), .in_den (rho_root),
      .out_valid (vld_cp), .out_q (cp)
   );

   shpe_div u_div_sp (
      .clock (clock), .reset (reset), .in_valid (sq_vld),
      .in_num (side_q.mag_y), .in_neg (side_q.neg_y), .in_den (rho_root),
      .out_valid (vld_sp), .out_q (sp)
   );

   assign div_vld = vld_ct & vld_st & vld_cp & vld_sp;

   // ---------------- products ----------------
   logic [BACK_STAGES-1:0] bvld_ff;
   qval_type ctq, stq, cpq, spq;
   qval_type a_ctct_ff, a_cs_ff, a_st2_ff, a_cpst_ff, a_spst_ff;
   qval_type a_cpcp_ff, a_spsp_ff, a_cpsp_ff, a_y10_ff, a_cp_ff, a_sp_ff;
   qval_type b_arg20_ff, b_c2_ff, b_s2_ff, b_p21a_ff, b_q21a_ff;
   qval_type b_p11_ff, b_q11_ff, b_st2_ff, b_y10_ff;
   qval_type c_y20_ff, c_p21_ff, c_q21_ff, c_c2st2_ff, c_s2st2_ff;
   qval_type c_y10_ff, c_p11_ff, c_q11_ff;
   qval_type d_re_in, d_im_in, d_re_ff, d_im_ff;
   qval_type y22_re, y22_im;
   qval_type e_re_ff, e_im_ff, amp_q;

   assign ctq   = qval_type'(ct);
   assign stq   = qval_type'(st);
   assign cpq   = qval_type'(cp);
   assign spq   = qval_type'(sp);
   assign amp_q = qval_type'(amplitude_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         bvld_ff <= '0;
      end else begin
         bvld_ff <= {bvld_ff[BACK_STAGES-2:0], div_vld};
      end
   end

   always_ff @(posedge clock) begin
      // A: first-order products of the angle terms
      a_ctct_ff <= mulq(ctq, ctq);
      a_cs_ff   <= mulq(ctq, stq);
      a_st2_ff  <= mulq(stq, stq);
      a_cpst_ff <= mulq(cpq, stq);
      a_spst_ff <= mulq(spq, stq);
      a_cpcp_ff <= mulq(cpq, cpq);
      a_spsp_ff <= mulq(spq, spq);
      a_cpsp_ff <= mulq(cpq, spq);
      a_y10_ff  <= mulq(K_Y10, ctq);
      a_cp_ff   <= cpq;
      a_sp_ff   <= spq;
      // B: combinations and second products
      b_arg20_ff <= a_ctct_ff + a_ctct_ff + a_ctct_ff - QONE;
      b_c2_ff    <= a_cpcp_ff - a_spsp_ff;
      b_s2_ff    <= a_cpsp_ff + a_cpsp_ff;
      b_p21a_ff  <= mulq(a_cp_ff, a_cs_ff);
      b_q21a_ff  <= mulq(a_sp_ff, a_cs_ff);
      b_p11_ff   <= mulq(K_Y11, a_cpst_ff);
      b_q11_ff   <= mulq(K_Y11, a_spst_ff);
      b_st2_ff   <= a_st2_ff;
      b_y10_ff   <= a_y10_ff;
      // C
      c_y20_ff   <= mulq(K_Y20, b_arg20_ff);
      c_p21_ff   <= mulq(K_Y21, b_p21a_ff);
      c_q21_ff   <= mulq(K_Y21, b_q21a_ff);
      c_c2st2_ff <= mulq(b_c2_ff, b_st2_ff);
      c_s2st2_ff <= mulq(b_s2_ff, b_st2_ff);
      c_y10_ff   <= b_y10_ff;
      c_p11_ff   <= b_p11_ff;
      c_q11_ff   <= b_q11_ff;
      // D: pick the term for the configured mode
      d_re_ff <= d_re_in;
      d_im_ff <= d_im_in;
      // E: amplitude
      e_re_ff <= mulq(d_re_ff, amp_q);
      e_im_ff <= mulq(d_im_ff, amp_q);
   end

   assign y22_re = mulq(K_Y22, c_c2st2_ff);
   assign y22_im = mulq(K_Y22, c_s2st2_ff);

   always_comb begin
      d_re_in = '0;
      d_im_in = '0;
      case (degree_ff)
         2'd0: begin
            d_re_in = K_Y00;
         end
         2'd1: begin
            if (order_ff == 3'sd0) begin
               d_re_in = c_y10_ff;
            end else begin
               d_re_in = order_ff[2] ? c_p11_ff : -c_p11_ff;
               d_im_in = -c_q11_ff;
            end
         end
         2'd2: begin
            if (order_ff == 3'sd0) begin
               d_re_in = c_y20_ff;
            end else if (order_ff == 3'sd1 || order_ff == -3'sd1) begin
               d_re_in = order_ff[2] ? c_p21_ff : -c_p21_ff;
               d_im_in = -c_q21_ff;
            end else begin
               d_re_in = y22_re;
               d_im_in = order_ff[2] ? -y22_im : y22_im;
            end
         end
         default: begin
            d_re_in = '0;
            d_im_in = '0;
         end
      endcase
   end

   // ---------------- F: saturate, output register ----------------
   logic signed [31:0] sat_re, sat_im;
   rsp_type            rsp_ff;
   logic               rsp_vld_ff;

   assign sat_re = (e_re_ff > SAT_MAX) ? 32'sh7fffffff :
                   (e_re_ff < SAT_MIN) ? 32'sh80000000 : e_re_ff[31:0];
   assign sat_im = (e_im_ff > SAT_MAX) ? 32'sh7fffffff :
                   (e_im_ff < SAT_MIN) ? 32'sh80000000 : e_im_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= bvld_ff[BACK_STAGES-2];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.field_real <= bad ? '0 : sat_re;
      rsp_ff.field_imag <= bad ? '0 : sat_im;
      rsp_ff.bad_mode   <= bad;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks ----------------
   `SHPE_ASSERT(a_fixed_latency, rsp_valid |-> $past(start && !busy, PIPE_LAT), "result without item")
   `SHPE_ASSERT(a_bad_is_zero, (rsp_valid && rsp_data.bad_mode) |-> (rsp_data.field_real == 32'sd0 && rsp_data.field_imag == 32'sd0), "bad mode with nonzero parts")
   `SHPE_ASSERT(a_root_order, sq_vld |-> (r_root >= rho_root), "rho root above r root")
   `SHPE_ASSERT(a_ct_range, div_vld |-> (ct <= 32'sd1073741824 && ct >= -32'sd1073741824), "cos theta out of range")
   `SHPE_ASSERT(a_sp_range, div_vld |-> (sp <= 32'sd1073741824 && sp >= -32'sd1073741824), "sin phi out of range")

endmodule
